// File: sv/lcd_video_ram_port_and_pixel_fetch_macros.svh
// Assertion macros shared by the video RAM port and pixel fetch block.
// Depends on nothing; included by the files that carry assertions.
`ifndef LCD_VIDEO_RAM_PORT_AND_PIXEL_FETCH_MACROS_SVH
`define LCD_VIDEO_RAM_PORT_AND_PIXEL_FETCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LVR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lvr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lvr assertion failed");

`endif

// File: sv/lvr_pkg.sv
// Package for the LCD video RAM port and pixel fetch block.
// Holds the request codes, register indexes, sizes and shared structs.
package lvr_pkg;

  localparam int VRAM_BYTES     = 16384;
  localparam int VRAM_PAIRS     = VRAM_BYTES / 2;
  localparam int ADDR_W         = $clog2(VRAM_PAIRS);
  localparam int SCREEN_LINES   = 150;
  localparam int SCREEN_COLUMNS = 160;

  localparam logic [7:0]        ROW_WRAP      = 8'hC8;
  localparam logic [7:0]        WIN_ROW       = 8'hD0;
  localparam logic [7:0]        MODE2_ROW     = 8'hF8;
  localparam logic [7:0]        TOP_WIN_LINES = 8'h10;
  localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(32);

  typedef enum logic [2:0] {
    FUNC_SET_LOW  = 3'd0,
    FUNC_SET_HIGH = 3'd1,
    FUNC_READ     = 3'd2,
    FUNC_WRITE    = 3'd3,
    FUNC_RENDER   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    REG_DISPLAY_BLANK = 3'd0,
    REG_STEP_BY_ROW   = 3'd1,
    REG_TOP_WINDOW    = 3'd2,
    REG_SWAP_PLANES   = 3'd3,
    REG_SCROLL_X      = 3'd4,
    REG_SCROLL_Y      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic       display_blank;
    logic       step_by_row;
    logic       top_window;
    logic       swap_planes;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        x_lo;
    logic              mute;
  } pix_loc_t;

endpackage

// File: sv/lvr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module lvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lvr_pix_addr.sv
// Maps a scanline and column to a video RAM byte pair address and bit position.
// Applies scroll, the fixed window modes, blanking and screen bounds; uses lvr_pkg.
module lvr_pix_addr (
  input  lvr_pkg::cfg_t     cfg,
  input  logic [7:0]        line,
  input  logic [7:0]        column,
  output lvr_pkg::pix_loc_t loc
);

  logic [8:0] row_sum;
  logic [8:0] row_wrapped;
  logic [7:0] row;
  logic [7:0] xoff;
  logic [7:0] x;
  logic       off_screen;

  always_comb begin
    row_sum     = {1'b0, line} + {1'b0, cfg.scroll_y};
    row_wrapped = (row_sum >= {1'b0, lvr_pkg::ROW_WRAP}) ?
                  row_sum - {1'b0, lvr_pkg::ROW_WRAP} : row_sum;
    row  = line;
    xoff = cfg.scroll_x;
    if (cfg.scroll_y < lvr_pkg::ROW_WRAP) begin
      row = row_wrapped[7:0];
      if (cfg.top_window && line < lvr_pkg::TOP_WIN_LINES) begin
        row  = lvr_pkg::WIN_ROW + line;
        xoff = 8'd0;
      end
    end else if (!cfg.scroll_y[3] && line <= {5'd0, cfg.scroll_y[2:0]}) begin
      row  = lvr_pkg::MODE2_ROW + line + {5'd0, ~cfg.scroll_y[2:0]};
      xoff = 8'd0;
    end
    x = column + xoff;
    off_screen = ({1'b0, line} >= 9'(lvr_pkg::SCREEN_LINES)) ||
                 ({1'b0, column} >= 9'(lvr_pkg::SCREEN_COLUMNS));
    loc.addr = {row, x[7:3]};
    loc.x_lo = x[2:0];
    loc.mute = cfg.display_blank || off_screen;
  end

endmodule

// File: sv/lcd_video_ram_port_and_pixel_fetch.sv
// Top level of the LCD video RAM port and pixel fetch block.
// Depends on lvr_pkg, lvr_ram, lvr_pix_addr and the assertion macro header.
//
// Usage: requests enter on the in_ channel (in_valid, in_stall, in_func, in_bus_data,
// in_line, in_column). Every accepted request gives exactly one result on the out_
// channel: out_read_byte for reads, out_pixel_value for renders, zero elsewhere.
// Registers are written via cfg_valid/cfg_ready with cfg_index and cfg_data; the user
// must do so only while no request is in flight (unenforced); cfg_ready is always high.
// Video RAM is split into two 8192-byte memories, one per bitplane, so a render
// reads both planes at once, while a bus write or read uses the byte of one of them.
// An accepted request goes through the memory read stage, then the output register.
// One request is taken per cycle while in_stall is low, set by the single access
// each memory makes per request. After reset the block sweeps both memories to zero,
// one pair a cycle, holding in_stall high until the sweep ends. When out_stall holds
// a result in the output register, one more request still enters the memory read
// stage; the next one is stalled until the output register frees up.
`include "lcd_video_ram_port_and_pixel_fetch_macros.svh"

module lcd_video_ram_port_and_pixel_fetch (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic [7:0] in_bus_data,
  input  logic [7:0] in_line,
  input  logic [7:0] in_column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte,
  output logic [1:0] out_pixel_value,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = lvr_pkg::ADDR_W;

  lvr_pkg::cfg_t     cfg_r, cfg_nxt;
  lvr_pkg::pix_loc_t loc;

  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic          plane_r, plane_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  lvr_pkg::func_t    s1_func_r;
  logic              s1_plane_r;
  logic [2:0]        s1_x_lo_r;
  logic              s1_mute_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_read_byte_r, out_read_byte_nxt;
  logic [1:0]        out_pixel_value_r, out_pixel_value_nxt;

  logic           in_accept;
  logic           advance;
  lvr_pkg::func_t func;
  logic [AW-1:0]  acc_step;
  logic           ram_we0, ram_we1, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     rdata0, rdata1;
  logic           pbit0, pbit1;

  assign func      = lvr_pkg::func_t'(in_func);
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = clr_busy_r || (s1_valid_r && !advance);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_read_byte   = out_read_byte_r;
  assign out_pixel_value = out_pixel_value_r;

  lvr_pix_addr u_pix_addr (
    .cfg    (cfg_r),
    .line   (in_line),
    .column (in_column),
    .loc    (loc)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (lvr_pkg::cfg_reg_t'(cfg_index))
        lvr_pkg::REG_DISPLAY_BLANK: cfg_nxt.display_blank = cfg_data[0];
        lvr_pkg::REG_STEP_BY_ROW:   cfg_nxt.step_by_row   = cfg_data[0];
        lvr_pkg::REG_TOP_WINDOW:    cfg_nxt.top_window    = cfg_data[0];
        lvr_pkg::REG_SWAP_PLANES:   cfg_nxt.swap_planes   = cfg_data[0];
        lvr_pkg::REG_SCROLL_X:      cfg_nxt.scroll_x      = cfg_data;
        lvr_pkg::REG_SCROLL_Y:      cfg_nxt.scroll_y      = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == {AW{1'b1}}) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    acc_step  = cfg_r.step_by_row ? lvr_pkg::ROW_STEP : AW'(1);
    acc_nxt   = acc_r;
    plane_nxt = plane_r;
    if (in_accept) begin
      case (func)
        lvr_pkg::FUNC_SET_LOW: begin
          acc_nxt   = {acc_r[AW-1:5], in_bus_data[4:0]};
          plane_nxt = in_bus_data[7];
        end
        lvr_pkg::FUNC_SET_HIGH: acc_nxt = {in_bus_data, acc_r[4:0]};
        lvr_pkg::FUNC_READ,
        lvr_pkg::FUNC_WRITE:    acc_nxt = acc_r + acc_step;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      ram_we0   = 1'b1;
      ram_we1   = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 8'd0;
    end else begin
      ram_we0   = in_accept && func == lvr_pkg::FUNC_WRITE && !plane_r;
      ram_we1   = in_accept && func == lvr_pkg::FUNC_WRITE && plane_r;
      ram_waddr = acc_r;
      ram_wdata = in_bus_data;
    end
    ram_re    = in_accept && (func == lvr_pkg::FUNC_READ || func == lvr_pkg::FUNC_RENDER);
    ram_raddr = (func == lvr_pkg::FUNC_RENDER) ? loc.addr : acc_r;
  end

  lvr_ram #(.WIDTH(8), .DEPTH(lvr_pkg::VRAM_PAIRS)) u_ram_plane0 (
    .clk   (clk),
    .we    (ram_we0),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata0)
  );

  lvr_ram #(.WIDTH(8), .DEPTH(lvr_pkg::VRAM_PAIRS)) u_ram_plane1 (
    .clk   (clk),
    .we    (ram_we1),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata1)
  );

  always_comb begin
    s1_valid_nxt = in_accept || (s1_valid_r && !advance);
    out_valid_nxt       = out_valid_r && out_stall;
    out_read_byte_nxt   = out_read_byte_r;
    out_pixel_value_nxt = out_pixel_value_r;
    pbit0 = rdata0[~s1_x_lo_r];
    pbit1 = rdata1[~s1_x_lo_r];
    if (s1_valid_r && advance) begin
      out_valid_nxt       = 1'b1;
      out_read_byte_nxt   = 8'd0;
      out_pixel_value_nxt = 2'd0;
      case (s1_func_r)
        lvr_pkg::FUNC_READ: out_read_byte_nxt = s1_plane_r ? rdata1 : rdata0;
        lvr_pkg::FUNC_RENDER: begin
          if (!s1_mute_r) begin
            out_pixel_value_nxt = cfg_r.swap_planes ? {pbit0, pbit1} : {pbit1, pbit0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      acc_r       <= '0;
      plane_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      acc_r       <= acc_nxt;
      plane_r     <= plane_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r  <= func;
      s1_plane_r <= plane_r;
      s1_x_lo_r  <= loc.x_lo;
      s1_mute_r  <= loc.mute;
    end
    out_read_byte_r   <= out_read_byte_nxt;
    out_pixel_value_r <= out_pixel_value_nxt;
  end

  `LVR_ASSERT_SAME(a_no_accept_while_clearing, clk, rst_n, clr_busy_r, in_stall)
  `LVR_ASSERT_NEXT(a_stuck_item_kept, clk, rst_n, s1_valid_r && !advance, s1_valid_r)
  `LVR_ASSERT_SAME(a_one_field_nonzero, clk, rst_n, out_valid_r,
                   out_read_byte_r == 8'd0 || out_pixel_value_r == 2'd0)
  `LVR_ASSERT_NEXT(a_address_steps, clk, rst_n,
                   in_accept && (func == lvr_pkg::FUNC_READ || func == lvr_pkg::FUNC_WRITE),
                   acc_r == $past(acc_r) + $past(acc_step))

endmodule
